[sv/cbcd_pkg.sv]
// shared types, constants and the color test for the blob centroid detector
// no dependencies
package cbcd_pkg;

  localparam int unsigned MAX_DIM   = 1024;
  localparam int unsigned MIN_HITS  = 5;

  localparam int unsigned PIX_W     = 16;
  localparam int unsigned COORD_W   = 10;
  localparam int unsigned DIM_W     = 11;
  localparam int unsigned SUM_W     = 28;
  localparam int unsigned CNT_W     = 19;
  localparam int unsigned REM_W     = CNT_W + 1;
  localparam int unsigned DIV_STEPS = SUM_W;
  localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  localparam logic [DIM_W-1:0] FRAME_WIDTH_RST  = 11'd320;
  localparam logic [DIM_W-1:0] FRAME_HEIGHT_RST = 11'd240;

  localparam logic [SUM_W-1:0] SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [7:0] R_MIN    = 8'd150;
  localparam logic [7:0] G_MIN    = 8'd120;
  localparam logic [7:0] B_MAX    = 8'd100;
  localparam logic [8:0] RB_GAP   = 9'd50;
  localparam logic [8:0] GB_GAP   = 9'd40;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic div_step;
    logic load_out;
  } cbcd_cmd_t;

  function automatic logic is_yellow(input logic [PIX_W-1:0] pix);
    logic [4:0] r5;
    logic [5:0] g6;
    logic [4:0] b5;
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    r5 = pix[15:11];
    g6 = pix[10:5];
    b5 = pix[4:0];
    r  = {r5, r5[4:2]};
    g  = {g6, g6[5:4]};
    b  = {b5, b5[4:2]};
    return (r > R_MIN) && (g > G_MIN) && (b < B_MAX) &&
           ({1'b0, r} > ({1'b0, b} + RB_GAP)) &&
           ({1'b0, g} > ({1'b0, b} + GB_GAP));
  endfunction

endpackage

[sv/cbcd_ctrl.sv]
// controller: handshakes, frame-end sequencing and divider step count
// depends on cbcd_pkg
module cbcd_ctrl (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  input  logic                 in_frame_last,
  output logic                 in_stall,
  output logic                 out_valid,
  input  logic                 out_stall,
  output cbcd_pkg::cbcd_cmd_t  cmd
);

  typedef enum logic [2:0] {
    ST_RUN  = 3'b001,
    ST_DIV  = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t                        state_r, state_nxt;
  logic [cbcd_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                          out_valid_r, out_valid_nxt;
  logic                          out_free;

  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != ST_RUN);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd           = '0;
    case (state_r)
      ST_RUN: begin
        cmd.accept = in_valid;
        if (in_valid && in_frame_last) begin
          state_nxt = ST_DIV;
          step_nxt  = '0;
        end
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        step_nxt     = step_r + cbcd_pkg::STEP_W'(1);
        if (step_r == cbcd_pkg::STEP_W'(cbcd_pkg::DIV_STEPS - 1)) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          cmd.load_out  = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_RUN;
        end
      end
      default: begin
        state_nxt = ST_RUN;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_RUN;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

[sv/cbcd_dp.sv]
// datapath: config registers, hit accumulators, bit-serial dividers, result register
// depends on cbcd_pkg
module cbcd_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cbcd_pkg::cbcd_cmd_t               cmd,
  input  logic                              cfg_we,
  input  logic [cbcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbcd_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic [cbcd_pkg::PIX_W-1:0]        in_pixel_rgb565,
  input  logic [cbcd_pkg::COORD_W-1:0]      in_pixel_col,
  input  logic [cbcd_pkg::COORD_W-1:0]      in_pixel_row,
  input  logic                              in_frame_last,
  output logic                              out_found,
  output logic [cbcd_pkg::COORD_W-1:0]      out_centroid_col,
  output logic [cbcd_pkg::COORD_W-1:0]      out_centroid_row,
  output logic signed [cbcd_pkg::DIM_W-1:0] out_offset_col,
  output logic signed [cbcd_pkg::DIM_W-1:0] out_offset_row
);

  localparam int unsigned SUM_W   = cbcd_pkg::SUM_W;
  localparam int unsigned CNT_W   = cbcd_pkg::CNT_W;
  localparam int unsigned REM_W   = cbcd_pkg::REM_W;
  localparam int unsigned COORD_W = cbcd_pkg::COORD_W;
  localparam int unsigned DIM_W   = cbcd_pkg::DIM_W;

  logic [DIM_W-1:0]   frame_width_r, frame_height_r;
  logic [SUM_W-1:0]   col_sum_r, col_sum_nxt;
  logic [SUM_W-1:0]   row_sum_r, row_sum_nxt;
  logic [CNT_W-1:0]   hit_total_r, hit_total_nxt;
  logic [SUM_W-1:0]   col_quo_r, row_quo_r;
  logic [REM_W-1:0]   col_rem_r, row_rem_r;
  logic [CNT_W-1:0]   divisor_r;
  logic               found_r;
  logic               res_found_r;
  logic [COORD_W-1:0] cx_r, cy_r;
  logic signed [DIM_W-1:0] ox_r, oy_r;

  logic               hit;
  logic [SUM_W:0]     col_add, row_add;
  logic [CNT_W:0]     cnt_add;
  logic [SUM_W-1:0]   col_sum_upd, row_sum_upd;
  logic [CNT_W-1:0]   hit_total_upd;
  logic [REM_W-1:0]   col_trial, row_trial;
  logic               col_ge, row_ge;
  logic [COORD_W-1:0] cx, cy;
  logic [DIM_W-1:0]   hx, hy;

  // pixel test and saturating accumulation
  always_comb begin
    hit = !in_pixel_col[0] && !in_pixel_row[0] &&
          (32'(in_pixel_col) < 32'(cbcd_pkg::MAX_DIM)) &&
          (32'(in_pixel_row) < 32'(cbcd_pkg::MAX_DIM)) &&
          cbcd_pkg::is_yellow(in_pixel_rgb565);
    col_add = {1'b0, col_sum_r} + (SUM_W+1)'(in_pixel_col);
    row_add = {1'b0, row_sum_r} + (SUM_W+1)'(in_pixel_row);
    cnt_add = {1'b0, hit_total_r} + (CNT_W+1)'(1);
    col_sum_upd   = col_add[SUM_W] ? cbcd_pkg::SUM_MAX : col_add[SUM_W-1:0];
    row_sum_upd   = row_add[SUM_W] ? cbcd_pkg::SUM_MAX : row_add[SUM_W-1:0];
    hit_total_upd = cnt_add[CNT_W] ? cbcd_pkg::COUNT_MAX : cnt_add[CNT_W-1:0];
    if (!hit) begin
      col_sum_upd   = col_sum_r;
      row_sum_upd   = row_sum_r;
      hit_total_upd = hit_total_r;
    end
    col_sum_nxt   = col_sum_r;
    row_sum_nxt   = row_sum_r;
    hit_total_nxt = hit_total_r;
    if (cmd.accept) begin
      if (in_frame_last) begin
        col_sum_nxt   = '0;
        row_sum_nxt   = '0;
        hit_total_nxt = '0;
      end else begin
        col_sum_nxt   = col_sum_upd;
        row_sum_nxt   = row_sum_upd;
        hit_total_nxt = hit_total_upd;
      end
    end
  end

  // one restoring division step per cycle on each axis
  always_comb begin
    col_trial = {col_rem_r[REM_W-2:0], col_quo_r[SUM_W-1]};
    row_trial = {row_rem_r[REM_W-2:0], row_quo_r[SUM_W-1]};
    col_ge    = col_trial >= {1'b0, divisor_r};
    row_ge    = row_trial >= {1'b0, divisor_r};
  end

  // result fields
  always_comb begin
    cx = col_quo_r[COORD_W-1:0];
    cy = row_quo_r[COORD_W-1:0];
    hx = {1'b0, frame_width_r[DIM_W-1:1]};
    hy = {1'b0, frame_height_r[DIM_W-1:1]};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r  <= cbcd_pkg::FRAME_WIDTH_RST;
      frame_height_r <= cbcd_pkg::FRAME_HEIGHT_RST;
      col_sum_r      <= '0;
      row_sum_r      <= '0;
      hit_total_r    <= '0;
    end else begin
      if (cfg_we && (cfg_index == cbcd_pkg::REG_FRAME_WIDTH)) begin
        frame_width_r <= cfg_wdata;
      end
      if (cfg_we && (cfg_index == cbcd_pkg::REG_FRAME_HEIGHT)) begin
        frame_height_r <= cfg_wdata;
      end
      col_sum_r   <= col_sum_nxt;
      row_sum_r   <= row_sum_nxt;
      hit_total_r <= hit_total_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept && in_frame_last) begin
      col_quo_r <= col_sum_upd;
      row_quo_r <= row_sum_upd;
      col_rem_r <= '0;
      row_rem_r <= '0;
      divisor_r <= hit_total_upd;
      found_r   <= hit_total_upd > CNT_W'(cbcd_pkg::MIN_HITS);
    end else if (cmd.div_step) begin
      col_quo_r <= {col_quo_r[SUM_W-2:0], col_ge};
      row_quo_r <= {row_quo_r[SUM_W-2:0], row_ge};
      col_rem_r <= col_ge ? (col_trial - {1'b0, divisor_r}) : col_trial;
      row_rem_r <= row_ge ? (row_trial - {1'b0, divisor_r}) : row_trial;
    end
    if (cmd.load_out) begin
      if (found_r) begin
        cx_r <= cx;
        cy_r <= cy;
        ox_r <= signed'({1'b0, cx} - hx);
        oy_r <= signed'(hy - {1'b0, cy});
      end else begin
        cx_r <= '0;
        cy_r <= '0;
        ox_r <= '0;
        oy_r <= '0;
      end
      res_found_r <= found_r;
    end
  end

  assign out_found        = res_found_r;
  assign out_centroid_col = cx_r;
  assign out_centroid_row = cy_r;
  assign out_offset_col   = ox_r;
  assign out_offset_row   = oy_r;

endmodule

[sv/color_blob_centroid_detector_top.sv]
// top level of the color blob centroid detector
// depends on cbcd_pkg, cbcd_ctrl and cbcd_dp
//
// usage: pixels arrive on the in_ channel (valid/stall), one request per
// pixel with its rgb565 color, column, row and a frame_last marker. pixels
// with even column and row that pass the fixed yellow test are summed.
// on the frame_last request one result leaves on the out_ channel: found,
// mean column and row, and offsets from the frame center (row axis up).
// with five hits or fewer, every result field is zero.
// throughput: one pixel per cycle within a frame. after frame_last the
// input stalls while the bit-serial dividers run (one quotient bit per
// cycle, the quotient as wide as the 28-bit sums) and until the result
// register is free and loaded; the result register and out_valid load together.
// a stalled result holds in its register; the next frame may stream in
// meanwhile, and only its own frame end waits for the register to free.
// reset (rst_n low, synchronous) clears sums, count and handshake state and
// sets frame_width to 320, frame_height to 240. cfg writes take effect at
// the next edge; the user makes them only while idle (not enforced here).
module color_blob_centroid_detector_top (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [cbcd_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [cbcd_pkg::DIM_W-1:0]        cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [cbcd_pkg::PIX_W-1:0]        in_pixel_rgb565,
  input  logic [cbcd_pkg::COORD_W-1:0]      in_pixel_col,
  input  logic [cbcd_pkg::COORD_W-1:0]      in_pixel_row,
  input  logic                              in_frame_last,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              out_found,
  output logic [cbcd_pkg::COORD_W-1:0]      out_centroid_col,
  output logic [cbcd_pkg::COORD_W-1:0]      out_centroid_row,
  output logic signed [cbcd_pkg::DIM_W-1:0] out_offset_col,
  output logic signed [cbcd_pkg::DIM_W-1:0] out_offset_row
);

  cbcd_pkg::cbcd_cmd_t cmd;

  cbcd_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_frame_last (in_frame_last),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .cmd           (cmd)
  );

  cbcd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_pixel_rgb565  (in_pixel_rgb565),
    .in_pixel_col     (in_pixel_col),
    .in_pixel_row     (in_pixel_row),
    .in_frame_last    (in_frame_last),
    .out_found        (out_found),
    .out_centroid_col (out_centroid_col),
    .out_centroid_row (out_centroid_row),
    .out_offset_col   (out_offset_col),
    .out_offset_row   (out_offset_row)
  );

endmodule
